[src/ira_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ira_pkg
// Shared widths, codes, stage control record and format bound functions for
// the intensity remap and convert pipeline.
// ----------------------------------------------------------------------------
package ira_pkg;

	localparam int PIX_W = 33;   // input pixel, signed
	localparam int VAL_W = 32;   // result value, signed
	localparam int D_W   = 34;   // divisor (source span)
	localparam int M_W   = 32;   // multiplier (format max or interval span)
	localparam int HALF_W = 17;  // split of the 34-bit magnitude for the multiplier
	localparam int PP_W  = HALF_W + M_W;
	localparam int P_W   = D_W + M_W;  // full product
	localparam int Q_W   = 34;   // quotient bits produced by the divider
	localparam int FL_W  = 38;   // floor result plus interval offset, signed
	localparam int IDX_W = 3;
	localparam int CFG_W = 33;

	// remap modes
	localparam logic [2:0] MODE_FULL     = 3'd0;
	localparam logic [2:0] MODE_INTERVAL = 3'd1;
	localparam logic [2:0] MODE_WINDOW   = 3'd2;
	localparam logic [2:0] MODE_MULT     = 3'd3;
	localparam logic [2:0] MODE_CONV     = 3'd4;

	// output formats
	localparam logic [2:0] FMT_S8  = 3'd0;
	localparam logic [2:0] FMT_U8  = 3'd1;
	localparam logic [2:0] FMT_S16 = 3'd2;
	localparam logic [2:0] FMT_U16 = 3'd3;
	localparam logic [2:0] FMT_S32 = 3'd4;
	localparam logic [2:0] FMT_U32 = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_FMT      = 3'd1;
	localparam logic [IDX_W-1:0] REG_SRC_LOW  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SRC_HIGH = 3'd3;
	localparam logic [IDX_W-1:0] REG_DST_LOW  = 3'd4;
	localparam logic [IDX_W-1:0] REG_DST_HIGH = 3'd5;

	// per-item control that travels with the data
	typedef struct packed {
		logic                    bad;        // invalid configuration
		logic                    early;      // result known without division
		logic signed [PIX_W-1:0] early_val;
		logic                    neg;        // dividend negative
		logic                    away;       // round half away from zero
		logic [2:0]              fmt;
		logic signed [VAL_W-1:0] add_a;      // interval offset
		logic [D_W-1:0]          d;
	} ctl_t;

	function automatic logic signed [VAL_W-1:0] fmt_max(input logic [2:0] f);
		case (f)
			FMT_S8:  fmt_max = 32'sd127;
			FMT_U8:  fmt_max = 32'sd255;
			FMT_S16: fmt_max = 32'sd32767;
			FMT_U16: fmt_max = 32'sd65535;
			default: fmt_max = 32'sd2147483647;
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] fmt_min(input logic [2:0] f);
		case (f)
			FMT_S8:  fmt_min = -32'sd128;
			FMT_S16: fmt_min = -32'sd32768;
			FMT_S32: fmt_min = -32'sd2147483647;
			default: fmt_min = 32'sd0;
		endcase
	endfunction

endpackage
`default_nettype wire

[src/ira_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ira_in_if / ira_out_if
// Valid/ready channels for pixels in and remapped results out.
// ----------------------------------------------------------------------------
interface ira_in_if import ira_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [PIX_W-1:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface ira_out_if import ira_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic [1:0]              status;
	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

[src/intensity_remap_and_convert.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// intensity_remap_and_convert
// Remaps integer pixels by one of five rules into an integer output format.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_ch, results leave on out_ch; both are valid/ready
//   channels and an item moves when valid and ready are high at a clock edge.
//   The registers (mode, format, source and destination bounds) must be
//   written through cfg_we / cfg_index / cfg_data while no item is in
//   flight; the block does not enforce this. There are three front stages
//   (decode, partial products, product sum), 34 divider stages producing
//   one quotient bit each, and two back stages (signed floor, round and
//   clamp into the output register). Throughput is one item per cycle
//   unless out_ch stalls; the one-bit-per-stage divider sets the depth.
//   When out_ch stalls with a result held, the whole pipeline holds and
//   in_ch.ready drops; nothing is lost or repeated.
//   Reset empties the pipeline and loads mode 0, format u8, source range
//   0..255 and destination range 0..255.
// ----------------------------------------------------------------------------
module intensity_remap_and_convert import ira_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	ira_in_if.sink                  in_ch,
	ira_out_if.source               out_ch,
	input  wire logic               cfg_we,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data
);

	logic [2:0]              mode_q, fmt_q;
	logic signed [PIX_W-1:0] src_low_q, src_high_q;
	logic signed [VAL_W-1:0] dst_low_q, dst_high_q;
	logic                    adv;

	logic                    f_valid, f_big;
	logic [P_W-1:0]          f_prod;
	ctl_t                    f_ctl;
	logic                    d_valid, d_big;
	logic [Q_W-1:0]          d_quot;
	logic [D_W-1:0]          d_rem;
	ctl_t                    d_ctl;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_FULL;
			fmt_q      <= FMT_U8;
			src_low_q  <= '0;
			src_high_q <= PIX_W'(255);
			dst_low_q  <= '0;
			dst_high_q <= VAL_W'(255);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[2:0];
				REG_FMT:      fmt_q      <= cfg_data[2:0];
				REG_SRC_LOW:  src_low_q  <= cfg_data;
				REG_SRC_HIGH: src_high_q <= cfg_data;
				REG_DST_LOW:  dst_low_q  <= cfg_data[VAL_W-1:0];
				REG_DST_HIGH: dst_high_q <= cfg_data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the pipe unless a held result is waiting
	assign adv         = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	ira_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_ch.valid),
		.pixel    (in_ch.pixel),
		.mode     (mode_q),
		.fmt      (fmt_q),
		.src_low  (src_low_q),
		.src_high (src_high_q),
		.dst_low  (dst_low_q),
		.dst_high (dst_high_q),
		.valid_s3 (f_valid),
		.prod_s3  (f_prod),
		.big_s3   (f_big),
		.ctl_s3   (f_ctl)
	);

	ira_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (f_valid),
		.prod      (f_prod),
		.big       (f_big),
		.ctl       (f_ctl),
		.out_valid (d_valid),
		.quot      (d_quot),
		.rem       (d_rem),
		.out_big   (d_big),
		.out_ctl   (d_ctl)
	);

	ira_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (d_valid),
		.quot        (d_quot),
		.rem         (d_rem),
		.big         (d_big),
		.ctl         (d_ctl),
		.out_valid_q (out_ch.valid),
		.value_q     (out_ch.value),
		.status_q    (out_ch.status)
	);

`ifndef SYNTHESIS
	// a bad configuration always reports a zero value
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_BAD |-> out_ch.value == '0)
		else $error("invalid configuration result carries nonzero value");

	// status never takes the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.status != 2'd3)
		else $error("unused status code");

	// a stalled pipe leaves the front and divider valid flags untouched
	a_hold_front: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(f_valid) && $stable(d_valid))
		else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

[src/ira_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ira_front
// Decodes the mode, forms dividend magnitude, multiplier and divisor, then
// builds the full product from two partial products over three stages.
// ----------------------------------------------------------------------------
module ira_front import ira_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic                    in_valid,
	input  wire logic signed [PIX_W-1:0] pixel,
	input  wire logic [2:0]              mode,
	input  wire logic [2:0]              fmt,
	input  wire logic signed [PIX_W-1:0] src_low,
	input  wire logic signed [PIX_W-1:0] src_high,
	input  wire logic signed [VAL_W-1:0] dst_low,
	input  wire logic signed [VAL_W-1:0] dst_high,
	output logic                         valid_s3,
	output logic [P_W-1:0]               prod_s3,
	output logic                         big_s3,
	output ctl_t                         ctl_s3
);

	logic signed [D_W-1:0]   x;
	logic signed [D_W-1:0]   span;
	logic signed [VAL_W:0]   dspan;
	logic [M_W-1:0]          m;
	logic                    fsgn;
	ctl_t                    ctl;

	logic                    valid_s1, valid_s2;
	logic [D_W-1:0]          ax_s1;
	logic [M_W-1:0]          m_s1;
	ctl_t                    ctl_s1, ctl_s2;
	logic [PP_W-1:0]         pplo_s2, pphi_s2;
	logic [P_W-1:0]          prod;

	// decode mode and set up the division
	always_comb begin
		span  = D_W'(src_high) - D_W'(src_low);
		dspan = (VAL_W+1)'(dst_high) - (VAL_W+1)'(dst_low);
		fsgn  = (fmt == FMT_S8) || (fmt == FMT_S16) || (fmt == FMT_S32);
		x     = D_W'(pixel) - D_W'(src_low);
		m     = M_W'(fmt_max(fmt));
		ctl.bad       = 1'b0;
		ctl.early     = 1'b0;
		ctl.early_val = pixel;
		ctl.away      = 1'b0;
		ctl.fmt       = fmt;
		ctl.add_a     = '0;
		ctl.d         = D_W'(span);
		if (fmt > FMT_U32 || mode > MODE_CONV) begin
			ctl.bad = 1'b1;
		end else begin
			case (mode)
				MODE_FULL: begin
					ctl.bad = !(src_low < src_high);
				end
				MODE_INTERVAL: begin
					ctl.bad   = !(src_low < src_high) || !(dst_low < dst_high);
					m         = dspan[M_W-1:0];
					ctl.add_a = dst_low;
					ctl.away  = fsgn;
				end
				MODE_WINDOW: begin
					ctl.bad  = !(src_low < src_high);
					ctl.away = fsgn;
					if (pixel <= src_low) begin
						ctl.early     = 1'b1;
						ctl.early_val = '0;
					end else if (pixel >= src_high) begin
						ctl.early     = 1'b1;
						ctl.early_val = PIX_W'(fmt_max(fmt));
					end
				end
				MODE_MULT: begin
					ctl.bad = (src_high <= 0);
					x       = D_W'(pixel);
					ctl.d   = D_W'(src_high);
				end
				default: begin
					ctl.early = 1'b1;
				end
			endcase
		end
		if (ctl.bad) begin
			ctl.d = D_W'(1);
		end
		ctl.neg = x[D_W-1];
	end

	// combine partial products; quotients too large to matter are flagged when the sum is registered
	always_comb begin
		prod = P_W'(pplo_s2) + (P_W'(pphi_s2) << HALF_W);
	end

	// advance all three stages together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1   <= x[D_W-1] ? D_W'(-x) : D_W'(x);
			m_s1    <= m;
			ctl_s1  <= ctl;
			pplo_s2 <= PP_W'(ax_s1[HALF_W-1:0]) * PP_W'(m_s1);
			pphi_s2 <= PP_W'(ax_s1[D_W-1:HALF_W]) * PP_W'(m_s1);
			ctl_s2  <= ctl_s1;
			prod_s3 <= prod;
			big_s3  <= (D_W'(prod[P_W-1:D_W]) >= ctl_s2.d);
			ctl_s3  <= ctl_s2;
		end
	end

endmodule
`default_nettype wire

[src/ira_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ira_divider
// Restoring divider unrolled into one register stage per quotient bit.
// ----------------------------------------------------------------------------
module ira_divider import ira_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           in_valid,
	input  wire logic [P_W-1:0] prod,
	input  wire logic           big,
	input  wire ctl_t           ctl,
	output logic                out_valid,
	output logic [Q_W-1:0]      quot,
	output logic [D_W-1:0]      rem,
	output logic                out_big,
	output ctl_t                out_ctl
);

	logic           valid_s [Q_W];
	logic [D_W-1:0] rem_s   [Q_W];
	logic [D_W-1:0] low_s   [Q_W];
	logic [Q_W-1:0] quot_s  [Q_W];
	logic           big_s   [Q_W];
	ctl_t           ctl_s   [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic           v_in;
		logic [D_W-1:0] r_in, l_in;
		logic [Q_W-1:0] q_in;
		logic           b_in;
		ctl_t           c_in;
		logic [D_W:0]   trial;
		logic           fits;

		if (k == 0) begin : g_first
			// quotients past the divider width are already saturated
			assign v_in = in_valid;
			assign r_in = big ? '0 : D_W'(prod[P_W-1:D_W]);
			assign l_in = prod[D_W-1:0];
			assign q_in = '0;
			assign b_in = big;
			assign c_in = ctl;
		end else begin : g_next
			assign v_in = valid_s[k-1];
			assign r_in = rem_s[k-1];
			assign l_in = low_s[k-1];
			assign q_in = quot_s[k-1];
			assign b_in = big_s[k-1];
			assign c_in = ctl_s[k-1];
		end

		// shift in one dividend bit, subtract where it fits
		assign trial = {r_in, l_in[D_W-1]};
		assign fits  = (trial >= {1'b0, c_in.d});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= fits ? D_W'(trial - {1'b0, c_in.d}) : D_W'(trial);
				low_s[k]  <= {l_in[D_W-2:0], 1'b0};
				quot_s[k] <= {q_in[Q_W-2:0], fits};
				big_s[k]  <= b_in;
				ctl_s[k]  <= c_in;
			end
		end
	end

	assign out_valid = valid_s[Q_W-1];
	assign quot      = quot_s[Q_W-1];
	assign rem       = rem_s[Q_W-1];
	assign out_big   = big_s[Q_W-1];
	assign out_ctl   = ctl_s[Q_W-1];

endmodule
`default_nettype wire

[src/ira_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ira_back
// Turns quotient and remainder into a signed floor, rounds, clamps to the
// output format and holds the result in the output register.
// ----------------------------------------------------------------------------
module ira_back import ira_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           in_valid,
	input  wire logic [Q_W-1:0] quot,
	input  wire logic [D_W-1:0] rem,
	input  wire logic           big,
	input  wire ctl_t           ctl,
	output logic                out_valid_q,
	output logic signed [VAL_W-1:0] value_q,
	output logic [1:0]          status_q
);

	logic                   valid_b1;
	logic signed [FL_W-1:0] fl_b1;
	logic [D_W-1:0]         rem_b1;
	logic                   big_b1;
	ctl_t                   ctl_b1;

	logic signed [FL_W-1:0] qx, fl0, fl;
	logic [D_W-1:0]         rm;

	logic [D_W:0]           twice;
	logic                   ge, eq;
	logic signed [FL_W-1:0] rnd, cand, lo_b, hi_b;
	logic signed [VAL_W-1:0] v_nx;
	logic [1:0]             st_nx;

	// floor of the signed quotient, plus interval offset
	always_comb begin
		qx = $signed(FL_W'(quot));
		rm = rem;
		if (!ctl.neg) begin
			fl0 = qx;
		end else if (rem == '0) begin
			fl0 = -qx;
		end else begin
			fl0 = -qx - FL_W'(1);
			rm  = ctl.d - rem;
		end
		fl = fl0 + FL_W'(ctl.add_a);
	end

	// round, take the early value where set, then clamp to the format; a bad setting gives zero
	always_comb begin
		twice = {rem_b1, 1'b0};
		ge    = (twice >= {1'b0, ctl_b1.d});
		eq    = (twice == {1'b0, ctl_b1.d});
		if (ctl_b1.away) begin
			if (fl_b1 > 0 || (fl_b1 == 0 && rem_b1 != '0)) begin
				rnd = fl_b1 + FL_W'(ge);
			end else begin
				rnd = fl_b1 - FL_W'(!ge) + FL_W'(!eq);
			end
		end else begin
			rnd = fl_b1 + FL_W'(ge);
			if (rnd < 0 && !eq) begin
				rnd = rnd + FL_W'(1);
			end
		end
		lo_b = FL_W'(fmt_min(ctl_b1.fmt));
		hi_b = FL_W'(fmt_max(ctl_b1.fmt));
		cand = ctl_b1.early ? FL_W'(ctl_b1.early_val) : rnd;
		if (ctl_b1.bad) begin
			v_nx  = '0;
			st_nx = ST_BAD;
		end else if (big_b1 && !ctl_b1.early) begin
			v_nx  = ctl_b1.neg ? VAL_W'(lo_b) : VAL_W'(hi_b);
			st_nx = ST_SAT;
		end else if (cand < lo_b) begin
			v_nx  = VAL_W'(lo_b);
			st_nx = ST_SAT;
		end else if (cand > hi_b) begin
			v_nx  = VAL_W'(hi_b);
			st_nx = ST_SAT;
		end else begin
			v_nx  = VAL_W'(cand);
			st_nx = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_b1    <= in_valid;
			out_valid_q <= valid_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_b1    <= fl;
			rem_b1   <= rm;
			big_b1   <= big;
			ctl_b1   <= ctl;
			value_q  <= v_nx;
			status_q <= st_nx;
		end
	end

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for intensity_remap_and_convert. A scoreboard predicts
// value and status for every accepted pixel with exact wide integer math.
// Directed cases cover each mode, each format, the range extremes and invalid
// settings (empty source, empty destination, bad high, bad mode and format
// codes). Random phases follow with random register settings and random
// idling on both channels.
module tb;
	import ira_pkg::*;

	typedef logic signed [127:0] wide_t;
	typedef logic signed [PIX_W-1:0] pix_t;

	localparam int LATENCY = 45;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int RAND_PHASES = 36;
	localparam int PHASE_ITEMS = 50;

	// Remap predictor with its own register copy and a queue of expected results
	class remap_scoreboard;
		logic [2:0] mode_r;
		logic [2:0] fmt_r;
		logic signed [32:0] src_lo_r;
		logic signed [32:0] src_hi_r;
		logic signed [31:0] dst_lo_r;
		logic signed [31:0] dst_hi_r;
		logic signed [VAL_W-1:0] value_q[$];
		logic [1:0] status_q[$];
		int mismatches;

		function new();
			mode_r = MODE_FULL;
			fmt_r = FMT_U8;
			src_lo_r = 0;
			src_hi_r = 255;
			dst_lo_r = 0;
			dst_hi_r = 255;
			mismatches = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_MODE:     mode_r = data[2:0];
				REG_FMT:      fmt_r = data[2:0];
				REG_SRC_LOW:  src_lo_r = data;
				REG_SRC_HIGH: src_hi_r = data;
				REG_DST_LOW:  dst_lo_r = data[31:0];
				REG_DST_HIGH: dst_hi_r = data[31:0];
				default: ;
			endcase
		endfunction

		// floor quotient and non-negative remainder of num / d, d > 0
		function void floor_div(wide_t num, wide_t d, output wide_t fl, output wide_t r);
			fl = num / d;
			r = num % d;
			if (r < 0) begin
				fl = fl - 1;
				r = r + d;
			end
		endfunction

		function wide_t half_up(wide_t fl, wide_t r, wide_t d);
			wide_t z;
			z = fl + ((2 * r >= d) ? 1 : 0);
			if (z < 0 && 2 * r != d)
				z = z + 1;
			return z;
		endfunction

		function wide_t half_away(wide_t fl, wide_t r, wide_t d);
			wide_t w;
			if (fl > 0 || (fl == 0 && r > 0))
				return fl + ((2 * r >= d) ? 1 : 0);
			w = fl - ((2 * r < d) ? 1 : 0);
			if (2 * r != d)
				w = w + 1;
			return w;
		endfunction

		// predict one pixel and queue the result
		function void note_pixel(pix_t pixel);
			wide_t p, lo, hi, a, b, d, fl, r, v, mx, mn;
			logic [1:0] st;
			logic sgn;
			p = pixel;
			lo = src_lo_r;
			hi = src_hi_r;
			a = dst_lo_r;
			b = dst_hi_r;
			v = 0;
			st = ST_OK;
			sgn = (fmt_r == FMT_S8 || fmt_r == FMT_S16 || fmt_r == FMT_S32);
			case (fmt_r)
				FMT_S8:  begin mx = 127; mn = -128; end
				FMT_U8:  begin mx = 255; mn = 0; end
				FMT_S16: begin mx = 32767; mn = -32768; end
				FMT_U16: begin mx = 65535; mn = 0; end
				FMT_S32: begin mx = 2147483647; mn = -2147483647; end
				default: begin mx = 2147483647; mn = 0; end
			endcase
			if (fmt_r > FMT_U32 || mode_r > MODE_CONV) begin
				st = ST_BAD;
			end else begin
				case (mode_r)
					MODE_FULL: begin
						if (lo >= hi) st = ST_BAD;
						else begin
							d = hi - lo;
							floor_div((p - lo) * mx, d, fl, r);
							v = half_up(fl, r, d);
						end
					end
					MODE_INTERVAL: begin
						if (lo >= hi || a >= b) st = ST_BAD;
						else begin
							d = hi - lo;
							floor_div((p - lo) * (b - a), d, fl, r);
							fl = fl + a;
							v = sgn ? half_away(fl, r, d) : half_up(fl, r, d);
						end
					end
					MODE_WINDOW: begin
						if (lo >= hi) st = ST_BAD;
						else if (p <= lo) v = 0;
						else if (p >= hi) v = mx;
						else begin
							d = hi - lo;
							floor_div((p - lo) * mx, d, fl, r);
							v = sgn ? half_away(fl, r, d) : half_up(fl, r, d);
						end
					end
					MODE_MULT: begin
						if (hi <= 0) st = ST_BAD;
						else begin
							floor_div(p * mx, hi, fl, r);
							v = half_up(fl, r, hi);
						end
					end
					default: v = p;
				endcase
				if (st != ST_BAD) begin
					if (v < mn) begin v = mn; st = ST_SAT; end
					else if (v > mx) begin v = mx; st = ST_SAT; end
				end
			end
			if (st == ST_BAD) v = 0;
			value_q.push_back(v[VAL_W-1:0]);
			status_q.push_back(st);
		endfunction

		function void check_result(logic signed [VAL_W-1:0] value, logic [1:0] status);
			if (value_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result value=%0d status=%0d",
						$time, value, status);
				return;
			end
			if (value !== value_q[0] || status !== status_q[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp value=%0d status=%0d got value=%0d status=%0d",
						$time, value_q[0], status_q[0], value, status);
			end
			void'(value_q.pop_front());
			void'(status_q.pop_front());
		endfunction

		function int pending();
			return value_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int idle_pct;
	int stall_pct;
	int hold_cycles;
	longint cycles;
	remap_scoreboard sb;

	ira_in_if in_ch();
	ira_out_if out_ch();

	intensity_remap_and_convert dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready = 1'b0;
				hold_cycles--;
			end else begin
				out_ch.ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// check every result that moves
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.value, out_ch.status);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// drop the input, wait until the pipe is empty, then load all registers
	task automatic load_setup(logic [2:0] mode, logic [2:0] fmt, logic signed [32:0] slo,
		logic signed [32:0] shi, logic signed [32:0] dlo, logic signed [32:0] dhi);
		in_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
		write_reg(REG_MODE, {30'b0, mode});
		write_reg(REG_FMT, {30'b0, fmt});
		write_reg(REG_SRC_LOW, slo);
		write_reg(REG_SRC_HIGH, shi);
		write_reg(REG_DST_LOW, dlo);
		write_reg(REG_DST_HIGH, dhi);
	endtask

	// offer one pixel until it is taken; leaves valid high
	task automatic send_pixel(pix_t pixel);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.pixel = pixel;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_pixel(pixel);
		@(negedge clk);
	endtask

	function automatic pix_t rand33();
		return {1'($urandom_range(1)), 32'($urandom)};
	endfunction

	function automatic pix_t pick_pixel();
		longint lo, hi, span;
		lo = sb.src_lo_r;
		hi = sb.src_hi_r;
		span = hi - lo;
		case ($urandom_range(9))
			0: return pix_t'(lo);
			1: return pix_t'(hi);
			2: return pix_t'(lo - 1);
			3: return pix_t'(hi + 1);
			4: return $urandom_range(1) ? -33'sd4294967296 : 33'sd4294967295;
			5: return rand33();
			6: return 33'($signed($urandom_range(511)) - 256);
			default: begin
				if (span > 0 && span < 64'h1_0000_0000)
					return pix_t'(lo + (longint'($urandom) % (span + 1)));
				return rand33();
			end
		endcase
	endfunction

	task automatic random_setup();
		logic [2:0] mode, fmt;
		longint slo, shi, dlo, dhi;
		mode = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
		fmt = ($urandom_range(9) < 8) ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
		case ($urandom_range(5))
			0: begin slo = $signed($urandom_range(2000)) - 1000;
				shi = slo + $urandom_range(2000, 1); end
			1: begin slo = -64'sd2147483648; shi = 64'sd4294967295; end
			2: begin slo = -64'sd4294967296; shi = 64'sd4294967295; end
			3: begin slo = rand33(); shi = rand33(); end
			4: begin slo = $urandom_range(1000); shi = slo + 1; end
			default: begin slo = $urandom_range(1000); shi = slo - $urandom_range(1); end
		endcase
		case ($urandom_range(4))
			0: begin dlo = $signed($urandom_range(2000)) - 1000;
				dhi = dlo + $urandom_range(2000, 1); end
			1: begin dlo = -64'sd2147483648; dhi = 64'sd2147483647; end
			2: begin dlo = $signed($urandom); dhi = $signed($urandom); end
			3: begin dlo = 0; dhi = 1; end
			default: begin dlo = 100; dhi = 100 - $urandom_range(1); end
		endcase
		// set the unused top bit of the destination bounds at random
		load_setup(mode, fmt, slo, shi, {1'($urandom_range(1)), 32'(dlo)},
			{1'($urandom_range(1)), 32'(dhi)});
	endtask

	initial begin
		sb = new();
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.pixel = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset setup: u8 full range, with both pixel extremes
		send_pixel(0);
		send_pixel(255);
		send_pixel(128);
		send_pixel(-1);
		send_pixel(-33'sd4294967296);
		send_pixel(33'sd4294967295);
		// interval into s8, rounding half away on negative values
		load_setup(MODE_INTERVAL, FMT_S8, 0, 10, -100, 100);
		send_pixel(0);
		send_pixel(10);
		send_pixel(1);
		send_pixel(-3);
		// window into s16
		load_setup(MODE_WINDOW, FMT_S16, 100, 200, 0, 1);
		send_pixel(50);
		send_pixel(150);
		send_pixel(200);
		// multiplicative into u16, negative clamps
		load_setup(MODE_MULT, FMT_U16, 0, 1000, 0, 1);
		send_pixel(333);
		send_pixel(-1000);
		// plain conversion into s32 and u32
		load_setup(MODE_CONV, FMT_S32, 0, 1, 0, 1);
		send_pixel(33'sd4294967295);
		send_pixel(-33'sd2147483648);
		load_setup(MODE_CONV, FMT_U32, 0, 1, 0, 1);
		send_pixel(-5);
		// invalid settings: empty source, empty destination, bad high, bad codes
		load_setup(MODE_FULL, FMT_U8, 7, 7, 0, 1);
		send_pixel(7);
		load_setup(MODE_INTERVAL, FMT_U8, 0, 9, 5, 5);
		send_pixel(3);
		load_setup(MODE_MULT, FMT_U8, 0, 0, 0, 1);
		send_pixel(3);
		load_setup(3'd6, FMT_U8, 0, 9, 0, 1);
		send_pixel(3);
		load_setup(MODE_FULL, 3'd7, 0, 9, 0, 1);
		send_pixel(3);

		// random phases, cycling the idling patterns
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			in_ch.valid = 1'b0;
			random_setup();
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 70; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 70; end
				default: begin idle_pct = 37; stall_pct = 37; end
			endcase
			// long receiver hold-off so the pipe fills and stalls its input
			if (ph == 4 || ph == 20)
				hold_cycles = 300;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_pixel(pick_pixel());
		end
		in_ch.valid = 1'b0;

		while (sb.pending() != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
